>>> rtl/mpt_pkg.sv
// shared types and constants for the mac peer table
`timescale 1ns / 1ps
`default_nettype none
package mpt_pkg;

   localparam int TABLE_SLOTS  = 16;
   localparam int MAC_W        = 48;
   localparam int OP_W         = 2;
   localparam int PEER_COUNT_W = 5;
   localparam int CNT_W        = $clog2(TABLE_SLOTS + 1);
   localparam int COUNT_MAX    = (1 << PEER_COUNT_W) - 1;
   localparam int COUNT_CAP    = (TABLE_SLOTS < COUNT_MAX) ? TABLE_SLOTS : COUNT_MAX;
   localparam int WIDE_W       = (CNT_W > PEER_COUNT_W) ? CNT_W : PEER_COUNT_W;

   typedef enum logic [OP_W-1:0] {
      OP_ADD    = 2'd0,
      OP_HAS    = 2'd1,
      OP_REMOVE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   // command token walking down the row of slots
   typedef struct packed {
      logic             vld;
      op_type           op;
      logic [MAC_W-1:0] mac;
      logic             hit;
      logic             claimed;
      logic [CNT_W-1:0] count;
   } tok_type;

   // end-of-walk broadcast: settle the tentatively claimed slot
   typedef struct packed {
      logic strobe;
      logic keep;
   } fin_type;

endpackage
`default_nettype wire

>>> rtl/mpt_cell.sv
// one table slot: stored mac, valid mark, and one stage of the command token
`timescale 1ns / 1ps
`default_nettype none
module mpt_cell (
   input  wire logic            clock,
   input  wire logic            reset,
   input  mpt_pkg::tok_type     tok_i,
   input  mpt_pkg::fin_type     fin_i,
   output mpt_pkg::tok_type     tok_o
);
   import mpt_pkg::*;

   logic [MAC_W-1:0] mac_ff, mac_in;
   logic             valid_ff, valid_in;
   logic             tent_ff, tent_in;
   tok_type          tok_ff, tok_in;
   logic             match;

   assign match = valid_ff && (mac_ff == tok_i.mac);

   always_comb begin
      mac_in   = mac_ff;
      valid_in = valid_ff;
      tent_in  = tent_ff;
      tok_in   = tok_i;

      // walk done: a claimed slot becomes valid unless the mac turned up later
      if (fin_i.strobe && tent_ff) begin
         valid_in = fin_i.keep;
         tent_in  = 1'b0;
      end

      if (tok_i.vld) begin
         unique case (tok_i.op)
            OP_ADD: begin
               if (match) begin
                  tok_in.hit = 1'b1;
               end else if (!valid_ff && !tok_i.hit && !tok_i.claimed) begin
                  mac_in         = tok_i.mac;
                  tent_in        = 1'b1;
                  tok_in.claimed = 1'b1;
               end
            end
            OP_HAS: begin
               if (match) begin
                  tok_in.hit = 1'b1;
               end
            end
            OP_REMOVE: begin
               if (match && !tok_i.hit) begin
                  valid_in   = 1'b0;
                  tok_in.hit = 1'b1;
               end
            end
            OP_CLEAR: begin
               valid_in = 1'b0;
            end
            default: begin
            end
         endcase
         tok_in.count = tok_i.count + CNT_W'(valid_in | tent_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         tent_ff    <= 1'b0;
         tok_ff.vld <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         tent_ff  <= tent_in;
         tok_ff   <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      mac_ff <= mac_in;
   end

   assign tok_o = tok_ff;

endmodule
`default_nettype wire

>>> rtl/mac_peer_table.sv
// mac peer table: a row of slot cells walked by one command token
// a command passes through the slot cells in order, one register per cell, and the
// result is registered once more from the last cell before the strobe
// a new command is taken only once the last one's result is shown; busy is high meanwhile
// reset: all valid marks clear at once, stored macs keep whatever they held
// results cannot be stalled: rsp_valid is a single-cycle strobe
`timescale 1ns / 1ps
`default_nettype none
module mac_peer_table (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [mpt_pkg::OP_W-1:0]         req_op,
   input  wire logic [mpt_pkg::MAC_W-1:0]        req_mac,
   output logic                                  rsp_valid,
   output logic                                  rsp_ok,
   output logic [mpt_pkg::PEER_COUNT_W-1:0]      rsp_peer_count
);
   import mpt_pkg::*;

   tok_type tok [TABLE_SLOTS+1];
   fin_type fin;
   tok_type tok_end;

   logic                    busy_ff, busy_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_ok_ff, rsp_ok_in;
   logic [PEER_COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic                    accept;
   logic [CNT_W-1:0]        count_adj;
   logic [WIDE_W-1:0]       count_wide;

   assign accept = start && !busy_ff;

   always_comb begin
      tok[0]         = '0;
      tok[0].vld     = accept;
      tok[0].op      = op_type'(req_op);
      tok[0].mac     = req_mac;
   end

   for (genvar i = 0; i < TABLE_SLOTS; i++) begin : g_cell
      mpt_cell u_cell (
         .clock (clock),
         .reset (reset),
         .tok_i (tok[i]),
         .fin_i (fin),
         .tok_o (tok[i+1])
      );
   end

   assign tok_end    = tok[TABLE_SLOTS];
   assign fin.strobe = tok_end.vld;
   assign fin.keep   = tok_end.claimed && !tok_end.hit;

   // a slot claimed before a later match was found is dropped from the count
   assign count_adj  = tok_end.count - CNT_W'(tok_end.claimed && tok_end.hit);
   assign count_wide = WIDE_W'(count_adj);

   always_comb begin
      busy_in      = busy_ff;
      rsp_valid_in = tok_end.vld;
      rsp_ok_in    = rsp_ok_ff;
      rsp_count_in = rsp_count_ff;
      if (accept) begin
         busy_in = 1'b1;
      end
      if (tok_end.vld) begin
         busy_in = 1'b0;
         unique case (tok_end.op)
            OP_ADD:    rsp_ok_in = tok_end.hit || tok_end.claimed;
            OP_HAS:    rsp_ok_in = tok_end.hit;
            OP_REMOVE: rsp_ok_in = tok_end.hit;
            OP_CLEAR:  rsp_ok_in = 1'b1;
            default:   rsp_ok_in = 1'b0;
         endcase
         rsp_count_in = (count_wide > WIDE_W'(COUNT_MAX)) ? PEER_COUNT_W'(COUNT_MAX)
                                                          : PEER_COUNT_W'(count_wide);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ok_ff    <= rsp_ok_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign busy           = busy_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_peer_count = rsp_count_ff;

endmodule
`default_nettype wire

>>> rtl/mpt_checker.sv
// port-level checks for the mac peer table, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module mpt_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             start,
   input wire logic                             busy,
   input wire logic                             rsp_valid,
   input wire logic [mpt_pkg::PEER_COUNT_W-1:0] rsp_peer_count
);
   import mpt_pkg::*;

   // one transaction in flight gives exactly one single-cycle strobe
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("rsp_valid held for more than one cycle");

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after an accepted transaction");

   a_free_at_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("busy still high while the result is shown");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_peer_count <= PEER_COUNT_W'(COUNT_CAP)))
      else $error("peer count beyond table size");

endmodule

bind mac_peer_table mpt_checker u_mpt_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_peer_count (rsp_peer_count)
);
`default_nettype wire
